>>> rtl/rgb_to_hsv_convert_top_defines.svh
// assertion macros shared by the rgb to hsv checker
`ifndef RGB_TO_HSV_CONVERT_TOP_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define RHC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define RHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rhc_pkg.sv
// types and constants of the rgb to hsv converter
package rhc_pkg;

  localparam int CH_W  = 8;
  localparam int HUE_W = 13;
  localparam int SAT_W = 11;
  localparam int BRI_W = 11;

  localparam int DIV_STEPS = 2;

  localparam int HUE_SPAN  = 60;
  localparam int DEG_GREEN = 120;
  localparam int DEG_BLUE  = 240;
  localparam int DEG_FULL  = 360;
  localparam int PCT_FULL  = 100;
  localparam int CH_MAX    = 255;

  localparam int DEG_W = 9;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_RED_WRAP,
    SECT_GREEN,
    SECT_BLUE
  } rhc_sect_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rhc_pix_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic             hue_undefined;
    logic [SAT_W-1:0] saturation;
    logic [BRI_W-1:0] brightness;
  } rhc_hsv_t;

  function automatic logic [DEG_W-1:0] hue_deg(input rhc_sect_e sect);
    logic [DEG_W-1:0] deg;
    case (sect)
      SECT_RED:      deg = '0;
      SECT_RED_WRAP: deg = DEG_W'(DEG_FULL);
      SECT_GREEN:    deg = DEG_W'(DEG_GREEN);
      SECT_BLUE:     deg = DEG_W'(DEG_BLUE);
      default:       deg = '0;
    endcase
    return deg;
  endfunction

endpackage

>>> rtl/rhc_div_pipe.sv
// pipelined restoring divider, two quotient bits per stage
module rhc_div_pipe import rhc_pkg::*; #(
  parameter int NUM_W  = 22,
  parameter int DEN_W  = 8,
  parameter int QUOT_W = 11
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic [QUOT_W-1:0] quot_o,
  output logic [DEN_W-1:0]  rem_o
);

  localparam int Stages = (QUOT_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int Steps  = Stages * DIV_STEPS;
  localparam int CmpW   = NUM_W + DEN_W;

  logic [CmpW-1:0]   rem_q  [Stages];
  logic [QUOT_W-1:0] quot_q [Stages];
  logic [DEN_W-1:0]  den_q  [Stages];

  logic [CmpW-1:0]   r_in  [Steps];
  logic [CmpW-1:0]   r_out [Steps];
  logic [QUOT_W-1:0] q_in  [Steps];
  logic [QUOT_W-1:0] q_out [Steps];
  logic [DEN_W-1:0]  d_in  [Steps];

  for (genvar t = 0; t < Steps; t++) begin : g_step
    localparam int Idx = QUOT_W - 1 - t;

    if (t == 0) begin : g_first
      assign r_in[t] = CmpW'(num_i);
      assign q_in[t] = '0;
      assign d_in[t] = den_i;
    end else if ((t % DIV_STEPS) == 0) begin : g_reg
      assign r_in[t] = rem_q[t/DIV_STEPS - 1];
      assign q_in[t] = quot_q[t/DIV_STEPS - 1];
      assign d_in[t] = den_q[t/DIV_STEPS - 1];
    end else begin : g_chain
      assign r_in[t] = r_out[t-1];
      assign q_in[t] = q_out[t-1];
      assign d_in[t] = d_in[t-1];
    end

    if (Idx >= 0) begin : g_work
      logic [CmpW-1:0] sub_w;
      logic            ge_w;
      assign sub_w    = CmpW'(d_in[t]) << Idx;
      assign ge_w     = (r_in[t] >= sub_w);
      assign r_out[t] = ge_w ? (r_in[t] - sub_w) : r_in[t];
      assign q_out[t] = q_in[t] | (QUOT_W'(ge_w) << Idx);
    end else begin : g_pass
      assign r_out[t] = r_in[t];
      assign q_out[t] = q_in[t];
    end
  end

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= r_out[k*DIV_STEPS + DIV_STEPS - 1];
        quot_q[k] <= q_out[k*DIV_STEPS + DIV_STEPS - 1];
        den_q[k]  <= d_in[k*DIV_STEPS + DIV_STEPS - 1];
      end
    end
  end

  assign quot_o = quot_q[Stages-1];
  assign rem_o  = rem_q[Stages-1][DEN_W-1:0];

endmodule

>>> rtl/rgb_to_hsv_convert_top.sv
// rgb to hsv converter, top level with sector decode and output register
//
// usage: one request on in_data_i (red, green, blue bytes) per cycle while
// in_valid_i is high and in_stall_o is low. one result leaves on out_data_o
// (hue, hue_undefined, saturation, brightness) for every request, in order.
// quotient width Q = clog2(100 * 2^FRAC_BITS + 1); the restoring dividers
// resolve two quotient bits per stage. throughput: one pixel per cycle while
// no shown result is held by out_stall_i.
// stages: channel compare and sector pick, constant scaling, the divider
// stages, then the hue fix-up into the output register.
// reset clears every valid bit; results in flight are dropped.
// when out_stall_i is high while a result is shown, the whole pipeline
// holds and in_stall_o goes high in the same cycle; with no result shown,
// requests keep flowing whatever out_stall_i does.
module rgb_to_hsv_convert_top import rhc_pkg::*; #(
  parameter int FRAC_BITS = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rhc_pix_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rhc_hsv_t out_data_o
);

  localparam int Scale     = 1 << FRAC_BITS;
  localparam int NumW      = $clog2(PCT_FULL * Scale * CH_MAX + 1);
  localparam int QuotW     = $clog2(PCT_FULL * Scale + 1);
  localparam int HueFullW  = $clog2(DEG_FULL * Scale + 1);
  localparam int DivStages = (QuotW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int HueExtW   = HueFullW + HUE_W;
  localparam int SatExtW   = QuotW + SAT_W;
  localparam int BriExtW   = QuotW + BRI_W;

  // brightness by reciprocal multiplication
  localparam int              BriShift  = NumW + CH_W;
  localparam longint unsigned BriRecip  =
    ((64'd1 << BriShift) + 64'(CH_MAX) - 64'd1) / 64'(CH_MAX);
  localparam longint unsigned BriMul    = BriRecip * (PCT_FULL * Scale);
  localparam int              BriProdW  = BriShift + QuotW;

  typedef struct packed {
    logic      und;
    logic      neg;
    rhc_sect_e sect;
  } rhc_side_t;

  logic adv;

  // sector decode
  logic            red_max, green_max;
  logic [CH_W-1:0] mx, mn, delta, num_p, num_m, abs_num;
  rhc_side_t       side_a;

  logic            vld_a_q;
  rhc_side_t       side_a_q;
  logic [CH_W-1:0] abs_a_q, delta_a_q, mx_a_q;

  // constant scaling
  logic                vld_b_q;
  rhc_side_t           side_b_q;
  logic [NumW-1:0]     hue_num_q, sat_num_q;
  logic [CH_W-1:0]     hue_den_q, sat_den_q;
  logic [BriProdW-1:0] bri_prod;
  logic [QuotW-1:0]    bri_b_q;

  // divider side lane
  logic             vld_q      [DivStages];
  rhc_side_t        side_q     [DivStages];
  logic [QuotW-1:0] bri_pipe_q [DivStages];

  logic [QuotW-1:0] hue_quot, sat_quot, bri_quot;
  logic [CH_W-1:0]  hue_rem;

  logic [HueFullW-1:0] hue_base, hue_q_ext, hue_full;
  logic [HueExtW-1:0]  hue_ext;
  logic [SatExtW-1:0]  sat_ext;
  logic [BriExtW-1:0]  bri_ext;
  rhc_hsv_t            res_d;

  logic     out_vld_q;
  rhc_hsv_t out_data_q;

  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_comb begin
    red_max   = (in_data_i.red >= in_data_i.green) && (in_data_i.red >= in_data_i.blue);
    green_max = !red_max && (in_data_i.green >= in_data_i.blue);
    if (red_max) begin
      mx    = in_data_i.red;
      num_p = in_data_i.green;
      num_m = in_data_i.blue;
    end else if (green_max) begin
      mx    = in_data_i.green;
      num_p = in_data_i.blue;
      num_m = in_data_i.red;
    end else begin
      mx    = in_data_i.blue;
      num_p = in_data_i.red;
      num_m = in_data_i.green;
    end
    mn = in_data_i.red;
    if (in_data_i.green < mn) mn = in_data_i.green;
    if (in_data_i.blue < mn) mn = in_data_i.blue;
    delta      = mx - mn;
    side_a.neg = (num_m > num_p);
    abs_num    = side_a.neg ? (num_m - num_p) : (num_p - num_m);
    side_a.und = (delta == '0);
    if (red_max) begin
      side_a.sect = side_a.neg ? SECT_RED_WRAP : SECT_RED;
    end else if (green_max) begin
      side_a.sect = SECT_GREEN;
    end else begin
      side_a.sect = SECT_BLUE;
    end
  end

  assign bri_prod = BriProdW'(mx_a_q) * BriProdW'(BriMul);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
      vld_q     <= '{default: 1'b0};
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_a_q   <= in_valid_i;
      vld_b_q   <= vld_a_q;
      vld_q[0]  <= vld_b_q;
      for (int k = 1; k < DivStages; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_vld_q <= vld_q[DivStages-1];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_a_q  <= side_a;
      abs_a_q   <= abs_num;
      delta_a_q <= delta;
      mx_a_q    <= mx;

      side_b_q  <= side_a_q;
      hue_num_q <= NumW'(abs_a_q) * NumW'(HUE_SPAN * Scale);
      sat_num_q <= NumW'(delta_a_q) * NumW'(PCT_FULL * Scale);
      bri_b_q   <= bri_prod[BriProdW-1 -: QuotW];
      hue_den_q <= side_a_q.und ? CH_W'(1) : delta_a_q;
      sat_den_q <= (mx_a_q == '0) ? CH_W'(1) : mx_a_q;

      side_q[0]     <= side_b_q;
      bri_pipe_q[0] <= bri_b_q;
      for (int k = 1; k < DivStages; k++) begin
        side_q[k]     <= side_q[k-1];
        bri_pipe_q[k] <= bri_pipe_q[k-1];
      end

      out_data_q <= res_d;
    end
  end

  rhc_div_pipe #(
    .NUM_W  (NumW),
    .DEN_W  (CH_W),
    .QUOT_W (QuotW)
  ) u_hue_div (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (hue_num_q),
    .den_i  (hue_den_q),
    .quot_o (hue_quot),
    .rem_o  (hue_rem)
  );

  rhc_div_pipe #(
    .NUM_W  (NumW),
    .DEN_W  (CH_W),
    .QUOT_W (QuotW)
  ) u_sat_div (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (sat_num_q),
    .den_i  (sat_den_q),
    .quot_o (sat_quot),
    .rem_o  ()
  );

  assign bri_quot = bri_pipe_q[DivStages-1];

  // hue fix-up, floor on the negative side
  always_comb begin
    hue_base  = HueFullW'(hue_deg(side_q[DivStages-1].sect)) << FRAC_BITS;
    hue_q_ext = HueFullW'(hue_quot);
    if (side_q[DivStages-1].neg) begin
      hue_full = hue_base - hue_q_ext - HueFullW'(hue_rem != '0);
    end else begin
      hue_full = hue_base + hue_q_ext;
    end
    hue_ext = HueExtW'(hue_full);
    sat_ext = SatExtW'(sat_quot);
    bri_ext = BriExtW'(bri_quot);

    res_d.hue           = side_q[DivStages-1].und ? '0 : hue_ext[HUE_W-1:0];
    res_d.hue_undefined = side_q[DivStages-1].und;
    res_d.saturation    = sat_ext[SAT_W-1:0];
    res_d.brightness    = bri_ext[BRI_W-1:0];
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/rhc_checker.sv
// port-level checker for the rgb to hsv converter and its bind
`include "rgb_to_hsv_convert_top_defines.svh"

module rhc_checker import rhc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input rhc_pix_t in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input rhc_hsv_t out_data_o
);

  `RHC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  `RHC_ASSERT_IMPLY(a_stall_src, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "request stalled with no result held")

  `RHC_ASSERT_IMPLY(a_grey, clk_i, rst_ni, out_valid_o && out_data_o.hue_undefined, (out_data_o.hue == '0) && (out_data_o.saturation == '0), "grey pixel with hue or saturation")

endmodule

bind rgb_to_hsv_convert_top rhc_checker u_rhc_checker (.*);

>>> test/rgb_to_hsv_convert_top_tb.sv
// testbench for the rgb to hsv converter: directed and random pixels checked by a scoreboard
module rgb_to_hsv_convert_top_tb;
  import rhc_pkg::*;

  localparam int FRAC_BITS      = 4;
  localparam int LIMIT          = 200000;
  localparam int HOLD_CYCLES    = 60;
  localparam int PHASE_PIXELS   = 476;
  localparam int SETTLE_CYCLES  = 20;
  localparam int N_CORNERS      = 22;

  class hsv_scoreboard;
    rhc_hsv_t hsv_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return hsv_q.size();
    endfunction

    function rhc_hsv_t convert_pixel(rhc_pix_t p);
      int r, g, b, mx, mn, delta, num, off, scale;
      rhc_sect_e sect;
      rhc_hsv_t hsv;
      r = p.red;
      g = p.green;
      b = p.blue;
      scale = 1 << FRAC_BITS;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      hsv = '0;
      if (delta == 0) begin
        hsv.hue_undefined = 1'b1;
      end else begin
        if (mx == r) sect = (g >= b) ? SECT_RED : SECT_RED_WRAP;
        else if (mx == g) sect = SECT_GREEN;
        else sect = SECT_BLUE;
        case (sect)
          SECT_RED: begin
            num = g - b;
            off = 0;
          end
          SECT_RED_WRAP: begin
            num = g - b;
            off = DEG_FULL;
          end
          SECT_GREEN: begin
            num = b - r;
            off = DEG_GREEN;
          end
          default: begin
            num = r - g;
            off = DEG_BLUE;
          end
        endcase
        hsv.hue = HUE_W'((HUE_SPAN * scale * num + off * scale * delta) / delta);
      end
      if (mx != 0) hsv.saturation = SAT_W'((PCT_FULL * scale * delta) / mx);
      hsv.brightness = BRI_W'((PCT_FULL * scale * mx) / CH_MAX);
      return hsv;
    endfunction

    function void note_pixel(rhc_pix_t p);
      hsv_q = {hsv_q, convert_pixel(p)};
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_val, act_val);
      end
    endfunction

    function void check_hsv(rhc_hsv_t got);
      rhc_hsv_t exp_hsv;
      if (hsv_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none got %h", $time, got);
        return;
      end
      exp_hsv = hsv_q.pop_front();
      compare_field("hue", exp_hsv.hue, got.hue);
      compare_field("hue_undefined", exp_hsv.hue_undefined, got.hue_undefined);
      compare_field("saturation", exp_hsv.saturation, got.saturation);
      compare_field("brightness", exp_hsv.brightness, got.brightness);
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  rhc_pix_t in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  rhc_hsv_t out_data_o;

  hsv_scoreboard sb = new();

  int send_idle = 0;
  int recv_idle = 0;
  int hold_go = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_cnt = 0;

  rhc_pix_t corner_pix [N_CORNERS] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF0100,
    24'h010000, 24'h000100, 24'h000001, 24'hFFFE00, 24'h00FFFE, 24'hFE00FF,
    24'h0100FF, 24'hC86432, 24'h80FF7F, 24'h7F80FF
  };

  rgb_to_hsv_convert_top #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_pixel(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_hsv(out_data_o);
    end
  end

  // receiver stall, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  function automatic rhc_pix_t random_pixel();
    rhc_pix_t p;
    p.red   = CH_W'($urandom);
    p.green = CH_W'($urandom);
    p.blue  = CH_W'($urandom);
    case ($urandom_range(9))
      0: begin
        p.green = p.red;
        p.blue  = p.red;
      end
      1: begin
        p.green = p.red;
        p.blue  = CH_W'($urandom_range(p.red));
      end
      2: begin
        p.blue = p.green;
        p.red  = CH_W'($urandom_range(p.green));
      end
      3: begin
        p.blue  = p.red;
        p.green = CH_W'($urandom_range(p.red));
      end
      4: begin
        p.green = p.red ^ CH_W'($urandom_range(3));
        p.blue  = p.red ^ CH_W'($urandom_range(3));
      end
      default: ;
    endcase
    return p;
  endfunction

  // called and returns at a falling edge
  task automatic send_pixel(rhc_pix_t p);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 36;
          recv_idle <= 86;
        end
        1: begin
          send_idle = 86;
          recv_idle <= 36;
        end
        default: begin
          send_idle = 0;
          recv_idle <= 0;
          hold_go <= hold_go + 1;
        end
      endcase
      if (ph == 0) begin
        for (int i = 0; i < N_CORNERS; i++) send_pixel(corner_pix[i]);
      end
      repeat (PHASE_PIXELS) send_pixel(random_pixel());
      drain_results();
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rhc_pkg.sv
rtl/rhc_div_pipe.sv
rtl/rgb_to_hsv_convert_top.sv
rtl/rhc_checker.sv
test/rgb_to_hsv_convert_top_tb.sv
